// ===== rtl/sacr_pkg.sv =====
// Shared types and constants for the set-associative cache replacement block.
`default_nettype none
package sacr_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_FIFO  = 2'd1;
  localparam logic [1:0] POL_SRRIP = 2'd2;
  localparam logic [1:0] POL_DRP   = 2'd3;

  localparam logic [1:0] OP_OTHER = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STORE = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_SETS   = 2'd2;

  localparam logic [1:0] RESET_POLICY = 2'd0;
  localparam logic [3:0] RESET_OFFSET = 4'd6;
  localparam logic [3:0] RESET_SETS   = 4'd7;

  localparam logic [1:0] RRPV_INSERT = 2'd2;
  localparam logic [1:0] RRPV_HIT    = 2'd0;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;

  localparam int ADDR_W = 48;
  localparam int CNT_W  = 48;

endpackage
`default_nettype wire

// ===== rtl/set_assoc_cache_replacement.sv =====
// Set-associative cache level with LRU, FIFO, SRRIP and DRP replacement.
// An accepted start steps through ST_ADDR, ST_SCAN, ST_DECIDE and ST_FINISH; out_valid is registered from ST_FINISH.
// A new access is taken only in idle, after the last result; one shared compare unit scans a way per cycle.
// Reset: a clearing pass writes every set row; busy stays high meanwhile.
// Configuration writes are always taken (cfg_ready is high).
// The receiver cannot stall: each result is shown for one cycle with out_valid.
`default_nettype none
module set_assoc_cache_replacement #(
  parameter int MAX_SETS     = 512,
  parameter int WAYS         = 4,
  parameter int REGRET_DEPTH = 4,
  parameter int TIME_BITS    = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [47:0] in_address,
  output logic             out_valid,
  output logic             out_hit,
  output logic [2:0]       out_way,
  output logic             out_evicted,
  output logic [47:0]      out_evicted_block_address,
  output logic             out_inserted_stable,
  output logic [47:0]      out_hit_total,
  output logic [47:0]      out_miss_total,
  output logic [47:0]      out_eviction_total,
  output logic [47:0]      out_load_total,
  output logic [47:0]      out_store_total,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  localparam int AW    = sacr_pkg::ADDR_W;
  localparam int CW    = sacr_pkg::CNT_W;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MSB   = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RF_W  = $clog2(REGRET_DEPTH + 1);
  localparam int KEY_W = TIME_BITS + 1;

  // set row storage
  logic [WAYS-1:0]                valid_mem  [MAX_SETS];
  logic [WAYS-1:0]                stable_mem [MAX_SETS];
  logic [WAYS-1:0][1:0]           rrpv_mem   [MAX_SETS];
  logic [WAYS-1:0][AW-1:0]        tag_mem    [MAX_SETS];
  logic [WAYS-1:0][TIME_BITS-1:0] last_mem   [MAX_SETS];
  logic [WAYS-1:0][TIME_BITS-1:0] ins_mem    [MAX_SETS];

  logic [WAYS-1:0]                rd_valid_r, rd_stable_r;
  logic [WAYS-1:0][1:0]           rd_rrpv_r;
  logic [WAYS-1:0][AW-1:0]        rd_tag_r;
  logic [WAYS-1:0][TIME_BITS-1:0] rd_last_r, rd_ins_r;

  logic [WAYS-1:0]                wr_valid, wr_stable;
  logic [WAYS-1:0][1:0]           wr_rrpv;
  logic [WAYS-1:0][AW-1:0]        wr_tag;
  logic [WAYS-1:0][TIME_BITS-1:0] wr_last, wr_ins;
  logic                           wr_en, rd_en;
  logic [SET_W-1:0]               wr_addr, rd_addr;

  sacr_pkg::state_t state_r, state_nxt;

  logic [1:0]           policy_r;
  logic [3:0]           offset_bits_r, set_bits_r;
  logic [1:0]           op_r;
  logic [AW-1:0]        addr_r, blk_r, blk_nxt, tag_r, tag_nxt, evaddr_r, evaddr_nxt;
  logic [SET_W-1:0]     set_r, set_nxt, clr_r, clr_nxt;
  logic [3:0]           sb_r, sb_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;

  logic             found_r, found_nxt, inv_r, inv_nxt, hit_r, hit_nxt, ev_r, ev_nxt;
  logic [WAY_W-1:0] scan_r, scan_nxt, hway_r, hway_nxt, iway_r, iway_nxt;
  logic [WAY_W-1:0] best_r, best_nxt, sway_r, sway_nxt, way_r, way_nxt;
  logic [KEY_W-1:0] bkey_r, bkey_nxt, key;
  logic [1:0]       mx_r, mx_nxt;

  logic [AW-1:0]    regret_r [REGRET_DEPTH];
  logic [AW-1:0]    regret_nxt [REGRET_DEPTH];
  logic [RF_W-1:0]  fill_r, fill_nxt;
  logic             in_regret;

  logic [CW-1:0] hits_r, hits_nxt, miss_r, miss_nxt, evs_r, evs_nxt;
  logic [CW-1:0] loads_r, loads_nxt, stores_r, stores_nxt;
  logic          out_valid_nxt, out_stable_nxt;

  logic [3:0]      sb_c;
  logic [AW-1:0]   blk_c;
  logic [SET_W-1:0] set_mask;
  logic [2:0]      age_sum [WAYS];

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != sacr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r      <= sacr_pkg::RESET_POLICY;
      offset_bits_r <= sacr_pkg::RESET_OFFSET;
      set_bits_r    <= sacr_pkg::RESET_SETS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacr_pkg::CFG_POLICY: policy_r      <= cfg_wdata[1:0];
        sacr_pkg::CFG_OFFSET: offset_bits_r <= cfg_wdata;
        sacr_pkg::CFG_SETS:   set_bits_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      valid_mem[wr_addr]  <= wr_valid;
      stable_mem[wr_addr] <= wr_stable;
      rrpv_mem[wr_addr]   <= wr_rrpv;
      tag_mem[wr_addr]    <= wr_tag;
      last_mem[wr_addr]   <= wr_last;
      ins_mem[wr_addr]    <= wr_ins;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r  <= valid_mem[rd_addr];
      rd_stable_r <= stable_mem[rd_addr];
      rd_rrpv_r   <= rrpv_mem[rd_addr];
      rd_tag_r    <= tag_mem[rd_addr];
      rd_last_r   <= last_mem[rd_addr];
      rd_ins_r    <= ins_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sacr_pkg::ST_CLEAR;
      clr_r     <= '0;
      time_r    <= '0;
      fill_r    <= '0;
      hits_r    <= '0;
      miss_r    <= '0;
      evs_r     <= '0;
      loads_r   <= '0;
      stores_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      time_r    <= time_nxt;
      fill_r    <= fill_nxt;
      hits_r    <= hits_nxt;
      miss_r    <= miss_nxt;
      evs_r     <= evs_nxt;
      loads_r   <= loads_nxt;
      stores_r  <= stores_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_op;
      addr_r <= in_address;
    end
    blk_r    <= blk_nxt;
    tag_r    <= tag_nxt;
    set_r    <= set_nxt;
    sb_r     <= sb_nxt;
    scan_r   <= scan_nxt;
    found_r  <= found_nxt;
    hway_r   <= hway_nxt;
    inv_r    <= inv_nxt;
    iway_r   <= iway_nxt;
    best_r   <= best_nxt;
    bkey_r   <= bkey_nxt;
    mx_r     <= mx_nxt;
    sway_r   <= sway_nxt;
    way_r    <= way_nxt;
    hit_r    <= hit_nxt;
    ev_r     <= ev_nxt;
    evaddr_r <= evaddr_nxt;
    for (int k = 0; k < REGRET_DEPTH; k++) begin
      regret_r[k] <= regret_nxt[k];
    end
    if (state_r == sacr_pkg::ST_FINISH) begin
      out_hit                   <= hit_r;
      out_way                   <= 3'(way_r);
      out_evicted               <= ev_r;
      out_evicted_block_address <= evaddr_r;
      out_inserted_stable       <= out_stable_nxt;
      out_hit_total             <= hits_nxt;
      out_miss_total            <= miss_nxt;
      out_eviction_total        <= evs_nxt;
      out_load_total            <= loads_nxt;
      out_store_total           <= stores_nxt;
    end
  end

  always_comb begin
    sb_c     = (set_bits_r > 4'(MSB)) ? 4'(MSB) : set_bits_r;
    blk_c    = addr_r >> offset_bits_r;
    set_mask = ~({SET_W{1'b1}} << sb_c);
    key      = {(policy_r == sacr_pkg::POL_DRP) ? rd_stable_r[scan_r] : 1'b0,
                (policy_r == sacr_pkg::POL_FIFO) ? rd_ins_r[scan_r] : rd_last_r[scan_r]};
    in_regret = 1'b0;
    for (int k = 0; k < REGRET_DEPTH; k++) begin
      if ((RF_W'(k) < fill_r) && (regret_r[k] == blk_r)) begin
        in_regret = 1'b1;
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      age_sum[k] = {1'b0, rd_rrpv_r[k]} + {1'b0, sacr_pkg::RRPV_DISTANT - mx_r};
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    time_nxt       = time_r;
    fill_nxt       = fill_r;
    hits_nxt       = hits_r;
    miss_nxt       = miss_r;
    evs_nxt        = evs_r;
    loads_nxt      = loads_r;
    stores_nxt     = stores_r;
    out_valid_nxt  = 1'b0;
    out_stable_nxt = 1'b0;
    blk_nxt        = blk_r;
    tag_nxt        = tag_r;
    set_nxt        = set_r;
    sb_nxt         = sb_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    hway_nxt       = hway_r;
    inv_nxt        = inv_r;
    iway_nxt       = iway_r;
    best_nxt       = best_r;
    bkey_nxt       = bkey_r;
    mx_nxt         = mx_r;
    sway_nxt       = sway_r;
    way_nxt        = way_r;
    hit_nxt        = hit_r;
    ev_nxt         = ev_r;
    evaddr_nxt     = evaddr_r;
    for (int k = 0; k < REGRET_DEPTH; k++) begin
      regret_nxt[k] = regret_r[k];
    end
    rd_en     = 1'b0;
    rd_addr   = (blk_c[SET_W-1:0]) & set_mask;
    wr_en     = 1'b0;
    wr_addr   = set_r;
    wr_valid  = rd_valid_r;
    wr_stable = rd_stable_r;
    wr_rrpv   = rd_rrpv_r;
    wr_tag    = rd_tag_r;
    wr_last   = rd_last_r;
    wr_ins    = rd_ins_r;

    case (state_r)
      sacr_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_r;
        wr_valid  = '0;
        wr_stable = '0;
        wr_rrpv   = {WAYS{sacr_pkg::RRPV_INSERT}};
        wr_tag    = '0;
        wr_last   = '0;
        wr_ins    = '0;
        clr_nxt   = clr_r + SET_W'(1);
        if (clr_r == SET_W'(MAX_SETS - 1)) begin
          state_nxt = sacr_pkg::ST_IDLE;
        end
      end
      sacr_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sacr_pkg::ST_ADDR;
          if (time_r != {TIME_BITS{1'b1}}) begin
            time_nxt = time_r + TIME_BITS'(1);
          end
        end
      end
      sacr_pkg::ST_ADDR: begin
        rd_en     = 1'b1;
        blk_nxt   = blk_c;
        set_nxt   = blk_c[SET_W-1:0] & set_mask;
        tag_nxt   = blk_c >> sb_c;
        sb_nxt    = sb_c;
        scan_nxt  = '0;
        found_nxt = 1'b0;
        inv_nxt   = 1'b0;
        state_nxt = sacr_pkg::ST_SCAN;
      end
      sacr_pkg::ST_SCAN: begin
        if (!found_r && rd_valid_r[scan_r] && (rd_tag_r[scan_r] == tag_r)) begin
          found_nxt = 1'b1;
          hway_nxt  = scan_r;
        end
        if (!inv_r && !rd_valid_r[scan_r]) begin
          inv_nxt  = 1'b1;
          iway_nxt = scan_r;
        end
        if ((scan_r == '0) || (key < bkey_r)) begin
          bkey_nxt = key;
          best_nxt = scan_r;
        end
        if ((scan_r == '0) || (rd_rrpv_r[scan_r] > mx_r)) begin
          mx_nxt   = rd_rrpv_r[scan_r];
          sway_nxt = scan_r;
        end
        scan_nxt = scan_r + WAY_W'(1);
        if (scan_r == WAY_W'(WAYS - 1)) begin
          state_nxt = sacr_pkg::ST_DECIDE;
        end
      end
      sacr_pkg::ST_DECIDE: begin
        hit_nxt    = found_r;
        ev_nxt     = !found_r && !inv_r;
        evaddr_nxt = '0;
        if (found_r) begin
          way_nxt = hway_r;
        end else if (inv_r) begin
          way_nxt = iway_r;
        end else begin
          way_nxt = (policy_r == sacr_pkg::POL_SRRIP) ? sway_r : best_r;
          evaddr_nxt = (rd_tag_r[way_nxt] << sb_r) | AW'(set_r);
          if (policy_r == sacr_pkg::POL_DRP) begin
            if (fill_r == RF_W'(REGRET_DEPTH)) begin
              for (int k = 0; k < REGRET_DEPTH; k++) begin
                regret_nxt[k] = (k == REGRET_DEPTH - 1) ? evaddr_nxt
                              : regret_r[(k == REGRET_DEPTH - 1) ? k : k + 1];
              end
            end else begin
              for (int k = 0; k < REGRET_DEPTH; k++) begin
                if (RF_W'(k) == fill_r) begin
                  regret_nxt[k] = evaddr_nxt;
                end
              end
              fill_nxt = fill_r + RF_W'(1);
            end
          end
        end
        state_nxt = sacr_pkg::ST_FINISH;
      end
      sacr_pkg::ST_FINISH: begin
        wr_en = 1'b1;
        if (hit_r) begin
          hits_nxt = sat_inc(hits_r);
          if ((policy_r == sacr_pkg::POL_LRU) || (policy_r == sacr_pkg::POL_DRP)) begin
            wr_last[way_r] = time_r;
          end else if (policy_r == sacr_pkg::POL_SRRIP) begin
            wr_rrpv[way_r] = sacr_pkg::RRPV_HIT;
          end
        end else begin
          miss_nxt = sat_inc(miss_r);
          if (ev_r) begin
            evs_nxt = sat_inc(evs_r);
            if (policy_r == sacr_pkg::POL_SRRIP) begin
              for (int k = 0; k < WAYS; k++) begin
                wr_rrpv[k] = (age_sum[k] > 3'd3) ? sacr_pkg::RRPV_DISTANT : age_sum[k][1:0];
              end
            end
          end
          wr_valid[way_r] = 1'b1;
          wr_tag[way_r]   = tag_r;
          wr_ins[way_r]   = time_r;
          wr_last[way_r]  = time_r;
          if (policy_r == sacr_pkg::POL_SRRIP) begin
            wr_rrpv[way_r] = sacr_pkg::RRPV_INSERT;
          end else if (policy_r == sacr_pkg::POL_DRP) begin
            wr_stable[way_r] = in_regret;
            out_stable_nxt   = in_regret;
          end
        end
        if (op_r == sacr_pkg::OP_LOAD) begin
          loads_nxt = sat_inc(loads_r);
        end else if (op_r == sacr_pkg::OP_STORE) begin
          stores_nxt = sat_inc(stores_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = sacr_pkg::ST_IDLE;
      end
      default: state_nxt = sacr_pkg::ST_IDLE;
    endcase
  end

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sacr_pkg::ST_CLEAR) |-> !out_valid)
    else $error("result during clearing pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == sacr_pkg::ST_ADDR) && !out_valid)
    else $error("accepted beat did not start lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit reported with eviction");

  a_evaddr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_block_address == '0))
    else $error("evicted address without eviction");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= RF_W'(REGRET_DEPTH))
    else $error("regret fill overflow");

endmodule
`default_nettype wire
